FILE: hw/rtl/midpoint_ellipse_rasterizer_core_assert.svh
// Assertion helpers shared by the rasterizer modules.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_CORE_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define MER_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define MER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mer_pkg.sv
`default_nettype none

package mer_pkg;

  localparam int CoordBitsDef  = 12;
  localparam int RadiusBitsDef = 11;
  localparam int PixW          = 14;

  localparam logic       OpStart = 1'b0;
  localparam logic       OpStep  = 1'b1;
  localparam logic [1:0] PtLast  = 2'd3;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL_AA,
    DP_MUL_BB,
    DP_MUL_A2B,
    DP_INIT_R1,
    DP_STEP_R1A,
    DP_STEP_R1B,
    DP_MUL_XX,
    DP_SUM_XX,
    DP_MUL_B2T,
    DP_MUL_YY,
    DP_MUL_A2YY,
    DP_MUL_A2B2,
    DP_SUB_A2B2,
    DP_FIX_R2,
    DP_STEP_R2A,
    DP_STEP_R2B,
    DP_EMIT
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQA,
    S_SQB,
    S_A2B,
    S_INIT,
    S_R1A,
    S_R1B,
    S_XX,
    S_SUMXX,
    S_B2T,
    S_YY,
    S_A2YY,
    S_A2B2,
    S_SUB,
    S_FIX,
    S_R2A,
    S_R2B,
    S_EMIT
  } ctl_state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] pt;
  } dp_cmd_t;

  typedef struct packed {
    logic finished;
    logic in_r1;
    logic r2_ready;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mer_ch_if.sv
`default_nettype none

interface mer_in_if import mer_pkg::*; #(
  parameter int COORD_BITS  = CoordBitsDef,
  parameter int RADIUS_BITS = RadiusBitsDef
) ();
  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [COORD_BITS-1:0]  centre_x;
  logic [COORD_BITS-1:0]  centre_y;
  logic [RADIUS_BITS-1:0] radius_a;
  logic [RADIUS_BITS-1:0] radius_b;

  modport source (
    output valid, opcode, centre_x, centre_y, radius_a, radius_b,
    input  ready
  );
  modport sink (
    input  valid, opcode, centre_x, centre_y, radius_a, radius_b,
    output ready
  );
endinterface

interface mer_out_if import mer_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [PixW-1:0] pixel_x;
  logic signed [PixW-1:0] pixel_y;
  logic                   last_of_four;
  logic                   ellipse_done;

  modport source (
    output valid, pixel_x, pixel_y, last_of_four, ellipse_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, last_of_four, ellipse_done,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/mer_datapath.sv
`default_nettype none

module mer_datapath import mer_pkg::*; #(
  parameter int COORD_BITS  = CoordBitsDef,
  parameter int RADIUS_BITS = RadiusBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_status_t             status_o,
  input  logic [COORD_BITS-1:0]  centre_x_i,
  input  logic [COORD_BITS-1:0]  centre_y_i,
  input  logic [RADIUS_BITS-1:0] radius_a_i,
  input  logic [RADIUS_BITS-1:0] radius_b_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic signed [PixW-1:0] pixel_x_o,
  output logic signed [PixW-1:0] pixel_y_o,
  output logic                   last_of_four_o,
  output logic                   ellipse_done_o
);

  localparam int SqW   = 2 * RADIUS_BITS;
  localparam int XW    = RADIUS_BITS + 1;
  localparam int MulW  = 2 * RADIUS_BITS + 2;
  localparam int ProdW = 2 * MulW;
  localparam int DxyW  = 3 * RADIUS_BITS + 4;
  localparam int WMax  = (COORD_BITS > XW) ? COORD_BITS : XW;
  localparam int ExtW  = (WMax + 1 > PixW) ? WMax + 1 : PixW;

  // control state
  logic region_two_q, region_two_d;
  logic r2_ready_q, r2_ready_d;
  logic finished_q, finished_d;
  logic out_valid_q, out_valid_d;

  // payload state
  logic [COORD_BITS-1:0]   cx_q, cx_d, cy_q, cy_d;
  logic [RADIUS_BITS-1:0]  ra_q, ra_d, rb_q, rb_d;
  logic [SqW-1:0]          a2_q, a2_d, b2_q, b2_d;
  logic [XW-1:0]           x_q, x_d;
  logic [RADIUS_BITS-1:0]  y_q, y_d;
  logic [DxyW-1:0]         dx_q, dx_d, dy_q, dy_d;
  logic signed [ProdW-1:0] dec_q, dec_d, acc_q, acc_d;
  logic [ProdW-1:0]        prod_q, prod_d;
  logic [MulW-1:0]         tmp_q, tmp_d;
  logic                    br_q, br_d;
  logic signed [PixW-1:0]  px_q, px_d, py_q, py_d;
  logic                    last_q, last_d, done_q, done_d;

  logic [MulW-1:0]         mul_a, mul_b;
  logic [RADIUS_BITS-1:0]  ym1;
  logic signed [ProdW-1:0] b2e, a2e, dxe, dye, prode;
  logic [ExtW-1:0]         sum_x, sum_y;

  assign ym1   = y_q - 1'b1;
  assign b2e   = $signed(ProdW'(b2_q));
  assign a2e   = $signed(ProdW'(a2_q));
  assign dxe   = $signed(ProdW'(dx_q));
  assign dye   = $signed(ProdW'(dy_q));
  assign prode = $signed(prod_q);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      DP_MUL_AA: begin
        mul_a = MulW'(ra_q);
        mul_b = MulW'(ra_q);
      end
      DP_MUL_BB: begin
        mul_a = MulW'(rb_q);
        mul_b = MulW'(rb_q);
      end
      DP_MUL_A2B: begin
        mul_a = MulW'(a2_q);
        mul_b = MulW'(rb_q);
      end
      DP_MUL_XX: begin
        mul_a = MulW'(x_q);
        mul_b = MulW'(x_q);
      end
      DP_MUL_B2T: begin
        mul_a = MulW'(b2_q);
        mul_b = tmp_q;
      end
      DP_MUL_YY: begin
        mul_a = MulW'(ym1);
        mul_b = MulW'(ym1);
      end
      DP_MUL_A2YY: begin
        mul_a = MulW'(a2_q);
        mul_b = prod_q[MulW-1:0];
      end
      DP_MUL_A2B2: begin
        mul_a = MulW'(a2_q);
        mul_b = MulW'(b2_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = ProdW'(mul_a) * ProdW'(mul_b);

  // point k: bit 0 mirrors x, bit 1 mirrors y
  assign sum_x = cmd_i.pt[0] ? ExtW'(cx_q) - ExtW'(x_q) : ExtW'(cx_q) + ExtW'(x_q);
  assign sum_y = cmd_i.pt[1] ? ExtW'(cy_q) - ExtW'(y_q) : ExtW'(cy_q) + ExtW'(y_q);

  always_comb begin
    region_two_d = region_two_q;
    r2_ready_d   = r2_ready_q;
    finished_d   = finished_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    cx_d   = cx_q;
    cy_d   = cy_q;
    ra_d   = ra_q;
    rb_d   = rb_q;
    a2_d   = a2_q;
    b2_d   = b2_q;
    x_d    = x_q;
    y_d    = y_q;
    dx_d   = dx_q;
    dy_d   = dy_q;
    dec_d  = dec_q;
    acc_d  = acc_q;
    tmp_d  = tmp_q;
    br_d   = br_q;
    px_d   = px_q;
    py_d   = py_q;
    last_d = last_q;
    done_d = done_q;
    unique case (cmd_i.op)
      DP_LOAD: begin
        cx_d = centre_x_i;
        cy_d = centre_y_i;
        ra_d = radius_a_i;
        rb_d = radius_b_i;
        x_d  = '0;
        y_d  = radius_b_i;
        dx_d = '0;
        region_two_d = 1'b0;
        r2_ready_d   = 1'b0;
      end
      DP_MUL_BB:  a2_d = prod_q[SqW-1:0];
      DP_MUL_A2B: b2_d = prod_q[SqW-1:0];
      DP_INIT_R1: begin
        dy_d  = {prod_q[DxyW-2:0], 1'b0};
        dec_d = b2e - prode + $signed(ProdW'(a2_q >> 2));
      end
      DP_STEP_R1A: begin
        x_d  = x_q + 1'b1;
        dx_d = dx_q + DxyW'({b2_q, 1'b0});
        br_d = dec_q[ProdW-1];
        if (!dec_q[ProdW-1]) begin
          y_d  = y_q - 1'b1;
          dy_d = dy_q - DxyW'({a2_q, 1'b0});
        end
      end
      DP_STEP_R1B: dec_d = dec_q + b2e + dxe - (br_q ? '0 : dye);
      DP_SUM_XX:   tmp_d = prod_q[MulW-1:0] + MulW'(x_q);
      DP_MUL_YY:   acc_d = prode;
      DP_MUL_A2B2: acc_d = acc_q + prode;
      DP_SUB_A2B2: acc_d = acc_q - prode + $signed(ProdW'(b2_q >> 2));
      DP_FIX_R2: begin
        // truncate toward zero: odd b2 leaves a quarter behind
        dec_d = acc_q + ((b2_q[0] && acc_q[ProdW-1]) ? ProdW'(1) : '0);
        region_two_d = 1'b1;
        r2_ready_d   = 1'b1;
      end
      DP_STEP_R2A: begin
        y_d  = y_q - 1'b1;
        dy_d = dy_q - DxyW'({a2_q, 1'b0});
        br_d = !dec_q[ProdW-1] && (dec_q != '0);
        if (dec_q[ProdW-1] || (dec_q == '0)) begin
          x_d  = x_q + 1'b1;
          dx_d = dx_q + DxyW'({b2_q, 1'b0});
        end
      end
      DP_STEP_R2B: dec_d = dec_q + a2e - dye + (br_q ? '0 : dxe);
      DP_EMIT: begin
        px_d   = $signed(sum_x[PixW-1:0]);
        py_d   = $signed(sum_y[PixW-1:0]);
        last_d = (cmd_i.pt == PtLast);
        done_d = (y_q == '0);
        finished_d  = (y_q == '0);
        out_valid_d = 1'b1;
      end
      default: begin
        out_valid_d = out_valid_q & ~out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_two_q <= 1'b0;
      r2_ready_q   <= 1'b0;
      finished_q   <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      region_two_q <= region_two_d;
      r2_ready_q   <= r2_ready_d;
      finished_q   <= finished_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    ra_q   <= ra_d;
    rb_q   <= rb_d;
    a2_q   <= a2_d;
    b2_q   <= b2_d;
    x_q    <= x_d;
    y_q    <= y_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    dec_q  <= dec_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    tmp_q  <= tmp_d;
    br_q   <= br_d;
    px_q   <= px_d;
    py_q   <= py_d;
    last_q <= last_d;
    done_q <= done_d;
  end

  assign status_o.finished = finished_q;
  assign status_o.in_r1    = !region_two_q && (dx_q < dy_q);
  assign status_o.r2_ready = r2_ready_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign last_of_four_o = last_q;
  assign ellipse_done_o = done_q;

  `include "midpoint_ellipse_rasterizer_core_assert.svh"

  `MER_ASSERT_IMPL(a_done_word_finished, clk_i, rst_ni, out_valid_q && done_q, finished_q, "done word pending while walk not finished")
  `MER_ASSERT_IMPL(a_region_two_ready, clk_i, rst_ni, region_two_q, r2_ready_q, "region two entered without its decision")
  `MER_ASSERT_NEXT(a_last_word, clk_i, rst_ni, cmd_i.op == DP_EMIT && cmd_i.pt == PtLast, out_valid_q && last_q, "fourth point not flagged last")

endmodule

`default_nettype wire

FILE: hw/rtl/mer_ctrl.sv
`default_nettype none

module mer_ctrl import mer_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_opcode_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctl_state_e state_q, state_d;
  logic [1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.op   = DP_NOP;
    cmd_o.pt   = cnt_q;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          if (in_opcode_i == OpStart) begin
            cmd_o.op = DP_LOAD;
            state_d  = S_SQA;
          end else begin
            // drop steps once the walk is over
            priority if (status_i.finished) state_d = S_IDLE;
            else if (status_i.in_r1)        state_d = S_R1A;
            else if (!status_i.r2_ready)    state_d = S_XX;
            else                            state_d = S_R2A;
          end
        end
      end
      S_SQA: begin
        cmd_o.op = DP_MUL_AA;
        state_d  = S_SQB;
      end
      S_SQB: begin
        cmd_o.op = DP_MUL_BB;
        state_d  = S_A2B;
      end
      S_A2B: begin
        cmd_o.op = DP_MUL_A2B;
        state_d  = S_INIT;
      end
      S_INIT: begin
        cmd_o.op = DP_INIT_R1;
        state_d  = S_EMIT;
      end
      S_R1A: begin
        cmd_o.op = DP_STEP_R1A;
        state_d  = S_R1B;
      end
      S_R1B: begin
        cmd_o.op = DP_STEP_R1B;
        state_d  = S_EMIT;
      end
      S_XX: begin
        cmd_o.op = DP_MUL_XX;
        state_d  = S_SUMXX;
      end
      S_SUMXX: begin
        cmd_o.op = DP_SUM_XX;
        state_d  = S_B2T;
      end
      S_B2T: begin
        cmd_o.op = DP_MUL_B2T;
        state_d  = S_YY;
      end
      S_YY: begin
        cmd_o.op = DP_MUL_YY;
        state_d  = S_A2YY;
      end
      S_A2YY: begin
        cmd_o.op = DP_MUL_A2YY;
        state_d  = S_A2B2;
      end
      S_A2B2: begin
        cmd_o.op = DP_MUL_A2B2;
        state_d  = S_SUB;
      end
      S_SUB: begin
        cmd_o.op = DP_SUB_A2B2;
        state_d  = S_FIX;
      end
      S_FIX: begin
        cmd_o.op = DP_FIX_R2;
        state_d  = S_R2A;
      end
      S_R2A: begin
        cmd_o.op = DP_STEP_R2A;
        state_d  = S_R2B;
      end
      S_R2B: begin
        cmd_o.op = DP_STEP_R2B;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        // hold the point until the output register frees up
        if (status_i.out_free) begin
          cmd_o.op = DP_EMIT;
          cnt_d    = cnt_q + 1'b1;
          if (cnt_q == PtLast) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `include "midpoint_ellipse_rasterizer_core_assert.svh"

  `MER_ASSERT_IMPL(a_emit_needs_room, clk_i, rst_ni, cmd_o.op == DP_EMIT, status_i.out_free, "point emitted into a full output register")
  `MER_ASSERT_NEXT(a_emit_ends, clk_i, rst_ni, state_q == S_EMIT && cnt_q == PtLast && status_i.out_free, state_q == S_IDLE, "no return to idle after fourth point")
  `MER_ASSERT_NEXT(a_finished_step_idle, clk_i, rst_ni, in_ready_o && in_valid_i && in_opcode_i == OpStep && status_i.finished, state_q == S_IDLE, "step after finish started work")

endmodule

`default_nettype wire

FILE: hw/rtl/midpoint_ellipse_rasterizer_core.sv
// Midpoint ellipse rasterizer.
// in_i takes command words: a start word (opcode 0) latches centre and
// radii and produces the four points at (0, b); a step word (opcode 1) runs
// one iteration of the midpoint walk and produces its four mirrored points.
// out_o carries one point per word, last_of_four on the fourth, and
// ellipse_done on all four points of the iteration that brings y to 0.
// Steps after that produce nothing.
// One word is worked on at a time; in_i.ready is high only when idle.
// The work per word is paced by the single shared multiplier and the four
// output writes; the first region-2 step also computes the exact
// region-2 decision, and a step after done goes straight back to idle.
// A stalled out_o holds the point in the output register and the walk
// waits for it; the next word can be taken while the last point waits.
// After reset the block is idle and steps are ignored until a start.

`default_nettype none

module midpoint_ellipse_rasterizer_core import mer_pkg::*; #(
  parameter int COORD_BITS  = CoordBitsDef,
  parameter int RADIUS_BITS = RadiusBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mer_in_if.sink        in_i,
  mer_out_if.source     out_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_opcode_i(in_i.opcode),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mer_datapath #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .centre_x_i    (in_i.centre_x),
    .centre_y_i    (in_i.centre_y),
    .radius_a_i    (in_i.radius_a),
    .radius_b_i    (in_i.radius_b),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .pixel_x_o     (out_o.pixel_x),
    .pixel_y_o     (out_o.pixel_y),
    .last_of_four_o(out_o.last_of_four),
    .ellipse_done_o(out_o.ellipse_done)
  );

endmodule

`default_nettype wire

FILE: verif/midpoint_ellipse_rasterizer_core_checker.sv
`timescale 1ns / 100ps

module midpoint_ellipse_rasterizer_core_checker import mer_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mer_in_if           in_mon,
  mer_out_if          out_mon,
  output int unsigned mismatch_count_o,
  output int unsigned pending_points_o,
  output int unsigned points_checked_o,
  output int unsigned ellipses_drawn_o,
  output logic        ellipse_active_o
);

  typedef struct packed {
    logic signed [PixW-1:0] pixel_x;
    logic signed [PixW-1:0] pixel_y;
    logic                   last_of_four;
    logic                   ellipse_done;
  } pixel_t;

  pixel_t expected_points[$];

  // Walk state of the ellipse being traced.
  bit                      in_region_two;
  bit                      region_two_set;
  bit                      walk_finished;
  longint                  pos_x;
  longint                  pos_y;
  longint                  step_dx;
  longint                  step_dy;
  longint                  decision;
  longint                  a_sq;
  longint                  b_sq;
  logic [CoordBitsDef-1:0] hold_cx;
  logic [CoordBitsDef-1:0] hold_cy;

  function automatic void reset_walk();
    in_region_two  = 1'b0;
    region_two_set = 1'b0;
    walk_finished  = 1'b1;
    pos_x          = 0;
    pos_y          = 0;
    step_dx        = 0;
    step_dy        = 0;
    decision       = 0;
    a_sq           = 0;
    b_sq           = 0;
    hold_cx        = '0;
    hold_cy        = '0;
  endfunction

  function automatic logic signed [PixW-1:0] wrap_pix(longint v);
    return v[PixW-1:0];
  endfunction

  // Queue the four mirrored points of the current (x, y).
  function automatic void queue_mirrored_points();
    pixel_t pt;
    logic   on_axis;
    longint cx;
    longint cy;
    on_axis       = (pos_y == 0);
    walk_finished = on_axis;
    cx            = longint'(hold_cx);
    cy            = longint'(hold_cy);
    for (int k = 0; k < 4; k++) begin
      pt.pixel_x      = wrap_pix((k % 2 == 1) ? cx - pos_x : cx + pos_x);
      pt.pixel_y      = wrap_pix((k >= 2) ? cy - pos_y : cy + pos_y);
      pt.last_of_four = (k == 3);
      pt.ellipse_done = on_axis;
      expected_points.push_back(pt);
    end
  endfunction

  function automatic void walk_ellipse(logic op, logic [CoordBitsDef-1:0] cx,
                                       logic [CoordBitsDef-1:0] cy,
                                       logic [RadiusBitsDef-1:0] ra,
                                       logic [RadiusBitsDef-1:0] rb);
    longint a;
    longint b;
    longint ym1;
    longint exact;
    if (op == OpStart) begin
      a              = longint'(ra);
      b              = longint'(rb);
      hold_cx        = cx;
      hold_cy        = cy;
      a_sq           = a * a;
      b_sq           = b * b;
      pos_x          = 0;
      pos_y          = b;
      step_dx        = 0;
      step_dy        = 2 * a_sq * b;
      decision       = b_sq - a_sq * b + a_sq / 4;
      in_region_two  = 1'b0;
      region_two_set = 1'b0;
      queue_mirrored_points();
      return;
    end
    if (walk_finished) return;
    if (!in_region_two && step_dx < step_dy) begin
      pos_x++;
      step_dx += 2 * b_sq;
      if (decision < 0) begin
        decision += b_sq + step_dx;
      end else begin
        pos_y--;
        step_dy  -= 2 * a_sq;
        decision += b_sq + step_dx - step_dy;
      end
      queue_mirrored_points();
      return;
    end
    // Entering region 2: exact decision, b2/4 truncated toward zero.
    if (!region_two_set) begin
      ym1   = pos_y - 1;
      exact = b_sq * (pos_x * pos_x + pos_x) + a_sq * ym1 * ym1 - a_sq * b_sq + b_sq / 4;
      if (b_sq[0] && exact < 0) exact++;
      decision       = exact;
      in_region_two  = 1'b1;
      region_two_set = 1'b1;
    end
    pos_y--;
    step_dy -= 2 * a_sq;
    if (decision > 0) begin
      decision += a_sq - step_dy;
    end else begin
      pos_x++;
      step_dx  += 2 * b_sq;
      decision += a_sq - step_dy + step_dx;
    end
    queue_mirrored_points();
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    if (mismatch_count_o < 100)
      $display("ERROR point %0d: %s expected %0d, got %0d", points_checked_o, what, want, got);
    mismatch_count_o++;
  endtask

  initial begin
    mismatch_count_o = 0;
    pending_points_o = 0;
    points_checked_o = 0;
    ellipses_drawn_o = 0;
    ellipse_active_o = 1'b0;
    reset_walk();
  end

  always @(posedge clk_i) begin
    pixel_t want;
    if (!rst_ni) begin
      reset_walk();
    end else begin
      // Check the word leaving first, then take the new command.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch("point with nothing pending, pixel_x", 0, out_mon.pixel_x);
        end else begin
          want = expected_points.pop_front();
          if (out_mon.pixel_x !== want.pixel_x)
            report_mismatch("pixel_x", want.pixel_x, out_mon.pixel_x);
          if (out_mon.pixel_y !== want.pixel_y)
            report_mismatch("pixel_y", want.pixel_y, out_mon.pixel_y);
          if (out_mon.last_of_four !== want.last_of_four)
            report_mismatch("last_of_four", want.last_of_four, out_mon.last_of_four);
          if (out_mon.ellipse_done !== want.ellipse_done)
            report_mismatch("ellipse_done", want.ellipse_done, out_mon.ellipse_done);
          if (want.last_of_four && want.ellipse_done) ellipses_drawn_o++;
          points_checked_o++;
        end
      end
      if (in_mon.valid && in_mon.ready)
        walk_ellipse(in_mon.opcode, in_mon.centre_x, in_mon.centre_y,
                     in_mon.radius_a, in_mon.radius_b);
      pending_points_o = expected_points.size();
      ellipse_active_o = !walk_finished;
    end
  end

endmodule

FILE: verif/midpoint_ellipse_rasterizer_core_test.sv
`timescale 1ns / 100ps

module midpoint_ellipse_rasterizer_core_test;
  import mer_pkg::*;

  localparam int IdleLimit  = 2000;
  localparam int WordTarget = 270;
  localparam int NoCap      = 1 << 20;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mer_in_if  in_ch ();
  mer_out_if out_ch ();

  int unsigned mismatch_count;
  int unsigned pending_points;
  int unsigned points_checked;
  int unsigned ellipses_drawn;
  logic        ellipse_active;

  int unsigned idle_cycles  = 0;
  int          ready_hold   = 0;
  bit          sender_gaps  = 1'b1;
  int unsigned starts_sent  = 0;
  int unsigned steps_sent   = 0;
  int unsigned idle_steps   = 0;
  int unsigned walk_words   = 0;

  midpoint_ellipse_rasterizer_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  midpoint_ellipse_rasterizer_core_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .mismatch_count_o (mismatch_count),
    .pending_points_o (pending_points),
    .points_checked_o (points_checked),
    .ellipses_drawn_o (ellipses_drawn),
    .ellipse_active_o (ellipse_active)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Output stalls: mostly short, a few long, with long stall-free runs.
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ch.ready) begin
      out_ch.ready <= 1'b0;
      ready_hold   <= ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
      ready_hold   <= ($urandom_range(0, 7) == 0) ? $urandom_range(60, 250) : $urandom_range(0, 8);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no word moved for %0d cycles", IdleLimit);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the caller either sends again or drops valid.
  task automatic send_word(input logic op, input logic [CoordBitsDef-1:0] cx,
                           input logic [CoordBitsDef-1:0] cy,
                           input logic [RadiusBitsDef-1:0] ra,
                           input logic [RadiusBitsDef-1:0] rb);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3))
        @(negedge clk_i);
    end
    if (op == OpStart) begin
      starts_sent++;
      walk_words++;
    end else begin
      steps_sent++;
      if (ellipse_active) walk_words++;
      else idle_steps++;
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.centre_x <= cx;
    in_ch.centre_y <= cy;
    in_ch.radius_a <= ra;
    in_ch.radius_b <= rb;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk_i);
  endtask

  // Geometry fields of a step are don't-care: fill them with noise.
  task automatic step_word();
    send_word(OpStep, CoordBitsDef'($urandom), CoordBitsDef'($urandom),
              RadiusBitsDef'($urandom), RadiusBitsDef'($urandom));
  endtask

  task automatic draw_ellipse(input logic [CoordBitsDef-1:0] cx,
                              input logic [CoordBitsDef-1:0] cy,
                              input logic [RadiusBitsDef-1:0] ra,
                              input logic [RadiusBitsDef-1:0] rb, input int max_steps);
    int n;
    n = 0;
    send_word(OpStart, cx, cy, ra, rb);
    while (ellipse_active && n < max_steps) begin
      step_word();
      n++;
    end
  endtask

  // Drop valid and wait on falling edges until no points are pending before the next word.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending_points != 0);
  endtask

  function automatic logic [RadiusBitsDef-1:0] pick_radius();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return RadiusBitsDef'($urandom_range(0, 8));
    if (r < 18) return RadiusBitsDef'($urandom_range(9, 24));
    return RadiusBitsDef'($urandom_range(25, 2047));
  endfunction

  initial begin
    logic [CoordBitsDef-1:0]  cx;
    logic [CoordBitsDef-1:0]  cy;
    logic [RadiusBitsDef-1:0] ra;
    logic [RadiusBitsDef-1:0] rb;
    int                       kind;
    int                       cap;
    bit                       drained;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = OpStep;
    in_ch.centre_x = '0;
    in_ch.centre_y = '0;
    in_ch.radius_a = '0;
    in_ch.radius_b = '0;
    out_ch.ready   = 1'b0;
    drained        = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: idle steps, flat ellipse, largest geometry, restart, zero a.
    step_word();
    send_word(OpStart, 12'd0, 12'd0, 11'd0, 11'd0);
    step_word();
    send_word(OpStart, 12'd4095, 12'd4095, 11'd2047, 11'd2047);
    repeat (3) step_word();
    draw_ellipse(12'd0, 12'd4095, 11'd0, 11'd3, NoCap);
    step_word();
    draw_ellipse(12'd2048, 12'd0, 11'd5, 11'd3, NoCap);
    draw_ellipse(12'd100, 12'd4000, 11'd7, 11'd0, NoCap);

    while (walk_words < WordTarget) begin
      sender_gaps = ($urandom_range(0, 9) >= 3);
      kind        = $urandom_range(0, 19);
      cx          = CoordBitsDef'($urandom);
      cy          = CoordBitsDef'($urandom);
      ra          = pick_radius();
      rb          = pick_radius();
      // Cut large ellipses short; their full walk can take thousands of steps.
      cap = (ra > 24 || rb > 24) ? $urandom_range(1, 6) : NoCap;
      if (kind < 15) begin
        draw_ellipse(cx, cy, ra, rb, cap);
        if ($urandom_range(0, 4) == 0) step_word();
      end else if (kind < 18) begin
        draw_ellipse(cx, cy, ra, rb, (cap == NoCap) ? $urandom_range(0, (ra + rb) / 2) : cap);
      end else begin
        repeat ($urandom_range(1, 3)) step_word();
      end
      if (!drained && walk_words >= WordTarget / 2) begin
        wait_drained();
        drained = 1'b1;
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("Sent %0d start and %0d step words (%0d steps with no walk in progress).",
             starts_sent, steps_sent, idle_steps);
    $display("Checked %0d points across %0d completed ellipses.", points_checked, ellipses_drawn);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
